// ----- design/vn2d_pkg.sv -----
// shared types and constants for the 2d value noise unit
package vn2d_pkg;

	localparam logic [31:0] PRIME_X = 32'd374761393;
	localparam logic [31:0] PRIME_Y = 32'd668265263;
	localparam logic [31:0] MIX_C1  = 32'h7feb352d;
	localparam logic [31:0] MIX_C2  = 32'h846ca68b;
	localparam logic [17:0] EASE_W3 = 18'd196608;
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = 2;

	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] seed;
		logic [15:0] tx;
		logic [15:0] ty;
	} vn2d_word_t;

endpackage

// ----- design/vn2d_front.sv -----
// front stage: floor, fraction and lattice row/column products
module vn2d_front import vn2d_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [31:0]       x_coord,
	input  logic [31:0]       y_coord,
	input  logic [31:0]       noise_seed,
	output logic              push,
	output vn2d_word_t        push_word,
	input  logic              q_full
);
	logic       valid_s1;
	vn2d_word_t word_s1;
	logic       adv;
	logic [31:0] x0, y0;
	logic [15:0] tx, ty;

	assign x0 = 32'($signed(x_coord) >>> FRAC_BITS);
	assign y0 = 32'($signed(y_coord) >>> FRAC_BITS);

	generate
		if (FRAC_BITS >= 16) begin : g_cut
			assign tx = x_coord[FRAC_BITS-1 -: 16];
			assign ty = y_coord[FRAC_BITS-1 -: 16];
		end else begin : g_pad
			assign tx = {x_coord[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
			assign ty = {y_coord[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
		end
	endgenerate

	assign adv       = !valid_s1 || !q_full;
	assign in_stall  = !adv;
	assign push      = valid_s1 && !q_full;
	assign push_word = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			word_s1.px   <= 32'(x0 * PRIME_X);
			word_s1.py   <= 32'(y0 * PRIME_Y);
			word_s1.seed <= noise_seed;
			word_s1.tx   <= tx;
			word_s1.ty   <= ty;
		end
	end
endmodule

// ----- design/vn2d_fifo.sv -----
// small queue between front and back
module vn2d_fifo import vn2d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  vn2d_word_t push_word,
	input  logic       pop,
	output vn2d_word_t pop_word,
	output logic       full,
	output logic       empty
);
	vn2d_word_t          mem [Q_DEPTH];
	logic [Q_AW-1:0]     wr_q, rd_q;
	logic [Q_AW:0]       cnt_q;

	assign full     = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_word = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + Q_AW'(1);
			if (pop) rd_q <= rd_q + Q_AW'(1);
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_word;
	end
endmodule

// ----- design/vn2d_back.sv -----
// back pipeline: corner hashes, easing and the three lerps
module vn2d_back import vn2d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  vn2d_word_t q_word,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [23:0] noise_value
);
	logic        en;
	logic [8:1]  v_q;
	logic [3:0][31:0] h_s1, h_s2, h_s3;
	logic [3:0][31:0] k;
	logic [15:0] tx_s1, ty_s1;
	logic [31:0] ttx_s2, tty_s2;
	logic [17:0] wx_s2, wy_s2;
	logic [49:0] ex_s3, ey_s3;
	logic [3:0][23:0] n_s4;
	logic [15:0] sx_s4, sy_s4, sy_s5, sy_s6, sy_s7;
	logic [41:0] plo_s5, phi_s5, pr_s7;
	logic [23:0] a0_s5, a1_s5, lo_s6, hi_s6, lo_s7, r_s8;
	logic [24:0] dlo, dhi, dr;
	logic [31:0] base, bx1;

	assign en          = !v_q[8] || !out_stall;
	assign pop         = en && !q_empty;
	assign out_valid   = v_q[8];
	assign noise_value = r_s8;

	// corner keys: x1*P = x0*P + P wraps the same way
	assign base = q_word.px + q_word.py + q_word.seed;
	assign bx1  = base + PRIME_X;
	assign k[0] = base;
	assign k[1] = bx1;
	assign k[2] = base + PRIME_Y;
	assign k[3] = bx1 + PRIME_Y;

	assign dlo = 25'(n_s4[1]) - 25'(n_s4[0]);
	assign dhi = 25'(n_s4[3]) - 25'(n_s4[2]);
	assign dr  = 25'(hi_s6) - 25'(lo_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[7:1], !q_empty};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				h_s1[i] <= k[i] ^ (k[i] >> 16);
				h_s2[i] <= 32'(h_s1[i] * MIX_C1);
				h_s3[i] <= 32'((h_s2[i] ^ (h_s2[i] >> 15)) * MIX_C2);
				n_s4[i] <= h_s3[i][23:0] ^ {8'b0, h_s3[i][31:16]};
			end
			tx_s1  <= q_word.tx;
			ty_s1  <= q_word.ty;
			ttx_s2 <= 32'(tx_s1) * 32'(tx_s1);
			tty_s2 <= 32'(ty_s1) * 32'(ty_s1);
			wx_s2  <= EASE_W3 - {1'b0, tx_s1, 1'b0};
			wy_s2  <= EASE_W3 - {1'b0, ty_s1, 1'b0};
			ex_s3  <= 50'(ttx_s2) * 50'(wx_s2);
			ey_s3  <= 50'(tty_s2) * 50'(wy_s2);
			sx_s4  <= ex_s3[47:32];
			sy_s4  <= ey_s3[47:32];
			plo_s5 <= 42'($signed(dlo) * $signed({1'b0, sx_s4}));
			phi_s5 <= 42'($signed(dhi) * $signed({1'b0, sx_s4}));
			a0_s5  <= n_s4[0];
			a1_s5  <= n_s4[2];
			sy_s5  <= sy_s4;
			// floor shift of the signed product
			lo_s6  <= 24'(26'(a0_s5) + plo_s5[41:16]);
			hi_s6  <= 24'(26'(a1_s5) + phi_s5[41:16]);
			sy_s6  <= sy_s5;
			pr_s7  <= 42'($signed(dr) * $signed({1'b0, sy_s6}));
			lo_s7  <= lo_s6;
			sy_s7  <= sy_s6;
			r_s8   <= 24'(26'(lo_s7) + pr_s7[41:16]);
		end
	end
endmodule

// ----- design/value_noise_2d_unit.sv -----
// top level of the 2d value noise unit
// Takes one point (signed fixed point x, y with FRAC_BITS fraction bits) and a
// seed per cycle and returns one 24-bit smoothstep value noise sample, 16777215
// meaning 1.0. Throughput is one item per clock while the output is not stalled;
// the path runs through one front register, one queue slot and eight back stages
// (key hashing, two hash multiplies, easing, three lerp steps). A four-entry
// queue decouples the front from the back pipeline.
module value_noise_2d_unit import vn2d_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] x_coord,
	input  logic [31:0] y_coord,
	input  logic [31:0] noise_seed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] noise_value
);
	logic       push, pop, q_full, q_empty;
	vn2d_word_t push_word, pop_word;

	vn2d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .x_coord, .y_coord, .noise_seed,
		.push, .push_word, .q_full
	);

	vn2d_fifo u_fifo (
		.clk, .arst_n, .push, .push_word, .pop, .pop_word,
		.full(q_full), .empty(q_empty)
	);

	vn2d_back u_back (
		.clk, .arst_n, .q_empty, .q_word(pop_word), .pop,
		.out_valid, .out_stall, .noise_value
	);

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !(push && !pop)) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !pop) else $error("pop from empty queue");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(noise_value))
		else $error("stalled result changed");
`endif
endmodule

// ----- sim/tb_value_noise_2d_unit.sv -----
// self-checking testbench for the 2d value noise unit
module tb_value_noise_2d_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS = 16;
	localparam logic [31:0] PRIME_X_TB = 32'd374761393;
	localparam logic [31:0] PRIME_Y_TB = 32'd668265263;
	localparam longint CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] x_coord;
	logic [31:0] y_coord;
	logic [31:0] noise_seed;
	logic        out_valid;
	logic        out_stall;
	logic [23:0] noise_value;

	logic [23:0] noise_due[$];
	int          err_count;
	longint      cycle_count;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_off_cycles;

	value_noise_2d_unit #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.x_coord(x_coord), .y_coord(y_coord), .noise_seed(noise_seed),
		.out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] hash_mix(input logic [31:0] v);
		logic [31:0] h;
		h = v ^ (v >> 16);
		h = h * 32'h7feb352d;
		h = h ^ (h >> 15);
		h = h * 32'h846ca68b;
		h = h ^ (h >> 16);
		return h;
	endfunction

	function automatic longint lattice_at(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] seed);
		logic [31:0] key;
		key = cx * PRIME_X_TB + cy * PRIME_Y_TB + seed;
		return longint'(hash_mix(key) & 32'hFFFFFF);
	endfunction

	function automatic longint smooth_frac(input logic [31:0] raw);
		longint t;
		t = longint'(raw[15:0]);
		return (t * t * (196608 - 2 * t)) >>> 32;
	endfunction

	// floor shift, also for negative steps
	function automatic longint mix_lin(input longint a, input longint b, input longint s);
		longint prod;
		prod = (b - a) * s;
		if (prod >= 0) begin
			return a + (prod >>> 16);
		end else begin
			return a - ((-prod + 65535) >>> 16);
		end
	endfunction

	function automatic logic [23:0] noise_at(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] seed);
		logic [31:0] x0, y0;
		longint sx, sy, lo, hi;
		x0 = $signed(px) >>> FRAC_BITS;
		y0 = $signed(py) >>> FRAC_BITS;
		sx = smooth_frac(px);
		sy = smooth_frac(py);
		lo = mix_lin(lattice_at(x0, y0, seed), lattice_at(x0 + 1, y0, seed), sx);
		hi = mix_lin(lattice_at(x0, y0 + 1, seed), lattice_at(x0 + 1, y0 + 1, seed), sx);
		return 24'(mix_lin(lo, hi, sy));
	endfunction

	// offers one word, with a random idle gap first, and waits for acceptance
	task automatic send_point(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] seed);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		x_coord    <= px;
		y_coord    <= py;
		noise_seed <= seed;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		noise_due.push_back(noise_at(px, py, seed));
	endtask

	// receiver stall pattern, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (noise_due.size() == 0) begin
				$error("noise_value: unexpected word, actual %0d", noise_value);
				err_count <= err_count + 1;
			end else begin
				if (noise_value !== noise_due[0]) begin
					$error("noise_value: expected %0d, actual %0d", noise_due[0], noise_value);
					err_count <= err_count + 1;
				end
				void'(noise_due.pop_front());
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("** value_noise_2d_unit: FAILED **");
		$finish;
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic test_extremes();
		logic [31:0] edges[8];
		edges = '{32'h0, 32'h0000FFFF, 32'h00010000, 32'h7FFFFFFF,
			32'h80000000, 32'hFFFFFFFF, 32'hFFFF0000, 32'h00008000};
		for (int i = 0; i < 8; i++) begin
			send_point(edges[i], edges[7 - i], 32'h0);
			send_point(edges[i], edges[(i + 3) % 8], 32'hFFFFFFFF);
		end
		// negative points: mid-cell, just above and just below a cell edge
		send_point(32'hFFFF8000, 32'hFFFE0001, 32'h12345678);
		send_point(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
		// last positive cell of the range
		send_point(32'h7FFF8000, 32'h7FFFC000, 32'hA5A5A5A5);
	endtask

	task automatic test_random(input int count);
		logic [31:0] px, py, seed;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: begin
					px = $urandom;
					py = $urandom;
				end
				1: begin
					px = 32'($signed($urandom_range(2000000)) - 1000000);
					py = 32'($signed($urandom_range(2000000)) - 1000000);
				end
				default: begin
					// random points in the cells from -3 to 3 on each axis
					px = {16'($urandom_range(6)) - 16'd3, 16'($urandom)};
					py = {16'($urandom_range(6)) - 16'd3, 16'($urandom)};
				end
			endcase
			seed = ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(3));
			send_point(px, py, seed);
		end
	endtask

	task automatic test_backpressure();
		set_idling(0, 0);
		hold_off_cycles = 60;
		test_random(40);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		x_coord = '0;
		y_coord = '0;
		noise_seed = '0;
		out_stall = 1'b0;
		err_count = 0;
		cycle_count = 0;
		hold_off_cycles = 0;
		set_idling(0, 0);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		set_idling(0, 0);
		test_random(400);
		set_idling(76, 0);
		test_random(350);
		set_idling(0, 76);
		test_random(350);
		set_idling(76, 76);
		test_random(100);
		set_idling(10, 10);
		test_random(300);
		test_backpressure();
		in_valid <= 1'b0;
		set_idling(0, 0);
		wait (noise_due.size() == 0);
		repeat (30) @(posedge clk);
		if (err_count == 0) begin
			$display("** value_noise_2d_unit: PASSED **");
		end else begin
			$display("** value_noise_2d_unit: FAILED **");
		end
		$finish;
	end

endmodule
